>>> design/raster_box_downscale_core_assert.svh
`ifndef RASTER_BOX_DOWNSCALE_CORE_ASSERT_SVH
`define RASTER_BOX_DOWNSCALE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define RBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define RBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rbd_pkg.sv
package rbd_pkg;

  localparam int CHANNELS   = 4;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 16;
  localparam int SUM_W      = 32;
  localparam int STEP_W     = 9;
  localparam int TGT_W      = 13;
  localparam int CNT_W      = 17;
  localparam int BAND_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAYER  = 2'd3;

  localparam logic [TGT_W-1:0] TGT_MIN = 13'd256;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_STEP,
    S_CHK,
    S_WRAP,
    S_ACC,
    S_DIV,
    S_PUT
  } state_t;

  typedef struct packed {
    logic cap_in;
    logic step_start;
    logic clr_start;
    logic clr_run;
    logic rd_en;
    logic acc_wr;
    logic div_start;
    logic out_load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic frame_start;
    logic reduce;
    logic step_done;
    logic clr_done;
    logic drop;
    logic band_wrap;
    logic emit;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> design/rbd_ram.sv
module rbd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/rbd_div.sv
// Restoring divider, one quotient bit per cycle. The upper dividend bits
// above the quotient must already be below the divisor.
module rbd_div #(
  parameter int NW = 17,
  parameter int DW = 13,
  parameter int QW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial   = {rem_r, q_r[QW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    q_nxt   = {q_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(dividend >> QW);
      q_r   <= dividend[QW-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> design/rbd_datapath.sv
module rbd_datapath #(
  parameter int MAX_OUT_WIDTH = 2048
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  input  logic [rbd_pkg::CHANNELS*rbd_pkg::SAMPLE_W-1:0] in_tdata,
  input  logic                                     out_tready,
  output logic                                     out_tvalid,
  output logic [95:0]                              out_tdata,
  output logic                                     out_tlast,
  input  rbd_pkg::cmd_t                            cmd,
  output rbd_pkg::sts_t                            sts
);

  localparam int AW    = $clog2(MAX_OUT_WIDTH);
  localparam int NCH   = rbd_pkg::CHANNELS;
  localparam int SW    = rbd_pkg::SAMPLE_W;
  localparam int PW    = rbd_pkg::POS_W;
  localparam int UW    = rbd_pkg::SUM_W;
  localparam int STW   = rbd_pkg::STEP_W;
  localparam int TW    = rbd_pkg::TGT_W;
  localparam int CW    = rbd_pkg::CNT_W;
  localparam int BW    = rbd_pkg::BAND_W;
  localparam int WORDW = NCH * UW + BW;

  // Configuration registers.
  logic [15:0] width_r, height_r;
  logic [11:0] target_r;
  logic        bayer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
      target_r <= 12'd1280;
      bayer_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rbd_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        rbd_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        rbd_pkg::REG_TARGET: target_r <= cfg_wdata[11:0];
        rbd_pkg::REG_BAYER:  bayer_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Position and block counters.
  logic [PW-1:0]  col_r, row_r, bx_r, by_r;
  logic [STW-1:0] ox_r, oy_r, step_r;
  logic [BW-1:0]  band_r;
  logic [AW-1:0]  clr_cnt_r;
  logic [CW-1:0]  count_r;
  logic [SW-1:0]  samp_r [NCH];

  logic [15:0]    w_eff, h_eff, m_dim;
  logic [TW-1:0]  t_clamp;
  logic [16:0]    step_dividend;
  logic [STW-1:0] step_q, step_fin, s_m1;
  logic           step_done;
  logic           last_col, last_row, band_start, reduce;
  logic [BW-1:0]  cur_band;
  logic [STW-1:0] ox1, oy1;

  always_comb begin
    w_eff   = (width_r == 16'd0) ? 16'd1 : width_r;
    h_eff   = (height_r == 16'd0) ? 16'd1 : height_r;
    m_dim   = (w_eff > h_eff) ? w_eff : h_eff;
    t_clamp = {1'b0, target_r};
    if (t_clamp < rbd_pkg::TGT_MIN) begin
      t_clamp = rbd_pkg::TGT_MIN;
    end
    if (t_clamp > TW'(MAX_OUT_WIDTH)) begin
      t_clamp = TW'(MAX_OUT_WIDTH);
    end
    step_dividend = 17'(m_dim) + 17'(t_clamp) - 17'd1;
    step_fin   = (!bayer_r || step_q <= STW'(1)) ? STW'(1) : step_q;
    s_m1       = step_r - 1'b1;
    last_col   = col_r >= (w_eff - 16'd1);
    last_row   = row_r >= (h_eff - 16'd1);
    band_start = (col_r == '0) && (oy_r == '0);
    reduce     = step_r > STW'(1);
    cur_band   = band_start ? band_r + 1'b1 : band_r;
    ox1        = ox_r + 1'b1;
    oy1        = oy_r + 1'b1;
  end

  rbd_div #(.NW(17), .DW(TW), .QW(STW)) u_step_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.step_start),
    .dividend (step_dividend),
    .divisor  (t_clamp),
    .done     (step_done),
    .quot     (step_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      bx_r      <= '0;
      by_r      <= '0;
      ox_r      <= '0;
      oy_r      <= '0;
      step_r    <= '0;
      band_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (step_done) begin
        step_r <= step_fin;
      end
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
        band_r    <= '0;
      end else if (cmd.clr_run) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.advance) begin
        if (reduce) begin
          band_r <= cur_band;
        end
        if (last_col) begin
          col_r <= '0;
          ox_r  <= '0;
          bx_r  <= '0;
          if (last_row) begin
            row_r <= '0;
            oy_r  <= '0;
            by_r  <= '0;
          end else begin
            row_r <= row_r + 1'b1;
            if (oy_r == s_m1) begin
              oy_r <= '0;
              by_r <= by_r + 1'b1;
            end else begin
              oy_r <= oy1;
            end
          end
        end else begin
          col_r <= col_r + 1'b1;
          if (ox_r == s_m1) begin
            ox_r <= '0;
            bx_r <= bx_r + 1'b1;
          end else begin
            ox_r <= ox1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      for (int c = 0; c < NCH; c++) begin
        samp_r[c] <= in_tdata[c*SW +: SW];
      end
    end
    if (cmd.rd_en) begin
      count_r <= CW'(18'(ox1) * 18'(oy1));
    end
  end

  // Column sum store; each word carries the band tag it was written in.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WORDW-1:0] ram_wdata, ram_rdata;
  logic [UW-1:0]    new_sum [NCH];
  logic             tag_hit;

  always_comb begin
    tag_hit = ram_rdata[WORDW-1 -: BW] == cur_band;
    for (int c = 0; c < NCH; c++) begin
      new_sum[c] = (tag_hit ? ram_rdata[c*UW +: UW] : '0) + UW'(samp_r[c]);
    end
    ram_we    = cmd.clr_run || cmd.acc_wr;
    ram_waddr = cmd.clr_run ? clr_cnt_r : bx_r[AW-1:0];
    ram_wdata = '0;
    if (!cmd.clr_run) begin
      ram_wdata[WORDW-1 -: BW] = cur_band;
      for (int c = 0; c < NCH; c++) begin
        ram_wdata[c*UW +: UW] = new_sum[c];
      end
    end
  end

  rbd_ram #(.W(WORDW), .D(MAX_OUT_WIDTH)) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (bx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // One rounding divider per channel.
  logic [SW-1:0] avg_q [NCH];
  logic [NCH-1:0] lane_done;

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    logic [UW:0] lane_dividend;
    assign lane_dividend = (UW+1)'(new_sum[g]) + (UW+1)'(count_r >> 1);
    rbd_div #(.NW(UW + 1), .DW(CW), .QW(SW)) u_avg_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_start),
      .dividend (lane_dividend),
      .divisor  (count_r),
      .done     (lane_done[g]),
      .quot     (avg_q[g])
    );
  end

  // Output register.
  logic        out_valid_r;
  logic [95:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int c = 0; c < NCH; c++) begin
        out_data_r[c*SW +: SW] <= reduce ? avg_q[c] : samp_r[c];
      end
      out_data_r[64 +: PW] <= reduce ? bx_r : col_r;
      out_data_r[80 +: PW] <= reduce ? by_r : row_r;
      out_last_r <= last_col && last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts.frame_start = (col_r == '0) && (row_r == '0);
    sts.reduce      = reduce;
    sts.step_done   = step_done;
    sts.clr_done    = cmd.clr_run && (clr_cnt_r == AW'(MAX_OUT_WIDTH - 1));
    sts.drop        = {1'b0, bx_r} >= (PW+1)'(MAX_OUT_WIDTH);
    sts.band_wrap   = band_start && (band_r == '1);
    sts.emit        = ((ox_r == s_m1) || last_col) && ((oy_r == s_m1) || last_row);
    sts.div_done    = lane_done[0];
    sts.out_free    = !out_valid_r || out_tready;
  end

endmodule

>>> design/rbd_ctrl.sv
module rbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rbd_pkg::sts_t sts,
  output rbd_pkg::cmd_t cmd
);

  rbd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbd_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbd_pkg::S_CLR: begin
        if (sts.clr_done) state_nxt = rbd_pkg::S_IDLE;
      end
      rbd_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = sts.frame_start ? rbd_pkg::S_STEP : rbd_pkg::S_CHK;
      end
      rbd_pkg::S_STEP: begin
        if (sts.step_done) state_nxt = rbd_pkg::S_CHK;
      end
      rbd_pkg::S_CHK: begin
        if (!sts.reduce) state_nxt = rbd_pkg::S_PUT;
        else if (sts.drop) state_nxt = rbd_pkg::S_IDLE;
        else if (sts.band_wrap) state_nxt = rbd_pkg::S_WRAP;
        else state_nxt = rbd_pkg::S_ACC;
      end
      rbd_pkg::S_WRAP: begin
        if (sts.clr_done) state_nxt = rbd_pkg::S_CHK;
      end
      rbd_pkg::S_ACC: begin
        state_nxt = sts.emit ? rbd_pkg::S_DIV : rbd_pkg::S_IDLE;
      end
      rbd_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = rbd_pkg::S_PUT;
      end
      rbd_pkg::S_PUT: begin
        if (sts.out_free) state_nxt = rbd_pkg::S_IDLE;
      end
      default: state_nxt = rbd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      rbd_pkg::S_CLR: cmd.clr_run = 1'b1;
      rbd_pkg::S_IDLE: begin
        in_tready      = 1'b1;
        cmd.cap_in     = in_tvalid;
        cmd.step_start = in_tvalid && sts.frame_start;
      end
      rbd_pkg::S_CHK: begin
        if (sts.reduce) begin
          if (sts.drop) cmd.advance = 1'b1;
          else if (sts.band_wrap) cmd.clr_start = 1'b1;
          else cmd.rd_en = 1'b1;
        end
      end
      rbd_pkg::S_WRAP: cmd.clr_run = 1'b1;
      rbd_pkg::S_ACC: begin
        cmd.acc_wr    = 1'b1;
        cmd.div_start = sts.emit;
        cmd.advance   = !sts.emit;
      end
      rbd_pkg::S_PUT: begin
        cmd.out_load = sts.out_free;
        cmd.advance  = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> design/raster_box_downscale_core.sv
// Channel     Direction  Payload (lowest bits first)
// cfg_*       in         index 0 width, 1 height, 2 target long edge, 3 reduce enable
// in_t*       in         tdata: sample_c0, sample_c1, sample_c2, sample_c3
// out_t*      out        tdata: avg_c0..avg_c3, out_x, out_y; tlast: frame_last
//
// One pixel is worked on at a time. A pixel that closes a block waits on the
// per-channel rounding dividers, and the first pixel of a frame waits for the
// step divider. After reset the sum store is swept over all MAX_OUT_WIDTH
// entries before the first transfer, and again every 65535 bands when the band
// tag wraps. A stalled result holds the output register and input.
module raster_box_downscale_core #(
  parameter int MAX_OUT_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_c0, sample_c1, sample_c2, sample_c3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // avg_c0, avg_c1, avg_c2, avg_c3, out_x, out_y
  output logic        out_tlast
);

  // The controller sequences each pixel; the datapath owns the counters, the
  // sum store, the dividers and the output register.
  rbd_pkg::cmd_t cmd;
  rbd_pkg::sts_t sts;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbd_datapath #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

>>> design/rbd_checker.sv
`include "raster_box_downscale_core_assert.svh"

module rbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tlast
);

  `RBD_ASSERT_NXT(a_out_valid_held, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `RBD_ASSERT_NXT(a_out_data_held, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  `RBD_ASSERT_NXT(a_one_pixel_at_a_time, in_tvalid && in_tready, !in_tready, "pixel taken while busy")
  `RBD_ASSERT_IMP(a_result_from_work, $rose(out_tvalid), $past(!in_tready), "result without work")

endmodule

bind raster_box_downscale_core rbd_checker u_rbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
